FILE: rtl/ssc_pkg.sv
`timescale 1ns / 1ps

package ssc_pkg;

  // switch / phase codes
  localparam logic [1:0] SW_NONE = 2'd0;
  localparam logic [1:0] SW_A    = 2'd1;
  localparam logic [1:0] SW_B    = 2'd2;
  localparam logic [1:0] SW_C    = 2'd3;

  localparam int unsigned NUM_PHASES = 6;
  localparam logic [2:0]  LAST_PHASE = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK   = 2'd1;

  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_MANUAL = 2'd2,
    OP_LOAD   = 2'd3
  } op_t;

  // drive on commutation, drive without crossing, new sense and edge
  typedef struct packed {
    logic [1:0] hc;
    logic [1:0] lc;
    logic [1:0] hs;
    logic [1:0] ls;
    logic [1:0] sns;
    logic       rise;
  } step_row_t;

  typedef struct packed {
    logic [1:0] hi;
    logic [1:0] lo;
    logic [1:0] sns;
    logic       rise;
  } manual_row_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] high_sel;
    logic [1:0] low_sel;
    logic [1:0] sense_sel;
    logic       edge_rising;
    logic [7:0] blank_count;
  } ctrl_state_t;

  localparam step_row_t STEP_FWD [0:NUM_PHASES-1] = '{
    '{SW_A, SW_C, SW_A, SW_B, SW_B, 1'b0},
    '{SW_B, SW_C, SW_A, SW_C, SW_A, 1'b1},
    '{SW_B, SW_A, SW_B, SW_C, SW_C, 1'b0},
    '{SW_C, SW_A, SW_B, SW_A, SW_B, 1'b1},
    '{SW_C, SW_B, SW_C, SW_A, SW_A, 1'b0},
    '{SW_A, SW_B, SW_C, SW_B, SW_C, 1'b1}
  };

  localparam step_row_t STEP_REV [0:NUM_PHASES-1] = '{
    '{SW_B, SW_C, SW_B, SW_A, SW_A, 1'b0},
    '{SW_A, SW_C, SW_B, SW_C, SW_B, 1'b1},
    '{SW_A, SW_B, SW_A, SW_C, SW_C, 1'b0},
    '{SW_C, SW_B, SW_A, SW_B, SW_A, 1'b1},
    '{SW_C, SW_A, SW_C, SW_B, SW_B, 1'b0},
    '{SW_B, SW_A, SW_C, SW_A, SW_C, 1'b1}
  };

  localparam manual_row_t MANUAL_FWD [0:NUM_PHASES-1] = '{
    '{SW_A, SW_B, SW_C, 1'b1},
    '{SW_A, SW_C, SW_B, 1'b0},
    '{SW_B, SW_C, SW_A, 1'b1},
    '{SW_B, SW_A, SW_C, 1'b0},
    '{SW_C, SW_A, SW_B, 1'b1},
    '{SW_C, SW_B, SW_A, 1'b0}
  };

  localparam manual_row_t MANUAL_REV [0:NUM_PHASES-1] = '{
    '{SW_B, SW_A, SW_C, 1'b1},
    '{SW_B, SW_C, SW_A, 1'b0},
    '{SW_A, SW_C, SW_B, 1'b1},
    '{SW_A, SW_B, SW_C, 1'b0},
    '{SW_C, SW_B, SW_A, 1'b1},
    '{SW_C, SW_A, SW_B, 1'b0}
  };

endpackage

FILE: rtl/sensorless_six_step_commutator_core.sv
`timescale 1ns / 1ps

// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+---------------------------------
// s_axis   | in        | s_axis_tvalid/tready    | tuser op, tdata sample fields
// m_axis   | out       | m_axis_tvalid/tready    | tdata drive and status word
// cfg      | in        | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// one word in, one word out; the result is registered at the edge that accepts the input
// a new input word is taken every cycle while the skid stage is empty; state updates in the accept cycle
// the output register plus a one-word skid stage keep input ready while a
// result waits; input stalls only when both hold a word
// rst is synchronous and clears state, configuration and the output buffer
// cfg_ready is always high; writes apply from the next cycle

module sensorless_six_step_commutator_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // input words
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] comp_high, [1] adc_window, [4:2] new_phase, [7:5] zero
  input  logic [ssc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] op
  input  logic [ssc_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // result words
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] high_side, [3:2] low_side, [5:4] sense_select, [6] sense_rising,
  // [9:7] current_phase, [10] commutated, [11] adc_trigger,
  // [27:12] commutation_count, [28] blanking_active, [31:29] zero
  output logic [ssc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssc_pkg::*;

  // configuration
  logic       reverse_direction;
  logic [7:0] blank_reload;

  // commutation state
  ctrl_state_t            state;
  ctrl_state_t            state_next;
  logic [COUNT_WIDTH-1:0] commute_total;
  logic [COUNT_WIDTH-1:0] commute_total_next;

  logic                   in_accept;
  logic                   commutated;
  logic                   adc_trigger;
  logic [COUNT_WIDTH+15:0] count_ext;
  logic [OUT_DATA_W-1:0]  result_word;

  assign cfg_ready = 1'b1;
  assign in_accept = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_direction <= 1'b0;
      blank_reload      <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REVERSE: reverse_direction <= cfg_data[0];
        REG_BLANK:   blank_reload      <= cfg_data[7:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  ssc_step u_step (
    .state             (state),
    .op                (op_t'(s_axis_tuser[1:0])),
    .comp_high         (s_axis_tdata[0]),
    .adc_window        (s_axis_tdata[1]),
    .new_phase         (s_axis_tdata[4:2]),
    .reverse_direction (reverse_direction),
    .blank_reload      (blank_reload),
    .state_next        (state_next),
    .commutated        (commutated),
    .adc_trigger       (adc_trigger)
  );

  // count wraps at its own width
  assign commute_total_next = commutated ? commute_total + 1'b1 : commute_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= '0;
      commute_total <= '0;
    end else if (in_accept) begin
      state         <= state_next;
      commute_total <= commute_total_next;
    end
  end

  // low 16 bits of the count, zero filled when the counter is narrower
  assign count_ext = {16'd0, commute_total_next};

  assign result_word = {
    3'd0,
    (state_next.blank_count != 8'd0),
    count_ext[15:0],
    adc_trigger,
    commutated,
    state_next.phase,
    state_next.edge_rising,
    state_next.sense_sel,
    state_next.low_sel,
    state_next.high_sel
  };

  ssc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (result_word),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // stored phase never leaves the six-step range
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    state.phase <= LAST_PHASE)
    else $error("phase register out of range");

  // a commutation bumps the count by exactly one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_accept && commutated |=> commute_total == $past(commute_total) + 1'b1)
    else $error("commutation count did not advance by one");

  // a commutation reloads blanking from the configured value
  a_blank_reload: assert property (@(posedge clk) disable iff (rst)
    in_accept && commutated |=> state.blank_count == $past(blank_reload))
    else $error("blanking not reloaded at commutation");

  // adc trigger only rides on a commutating word
  a_adc_on_commute: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[10])
    else $error("adc trigger without commutation");

endmodule

FILE: rtl/ssc_step.sv
`timescale 1ns / 1ps

module ssc_step (
  input  ssc_pkg::ctrl_state_t state,
  input  ssc_pkg::op_t         op,
  input  logic                 comp_high,
  input  logic                 adc_window,
  input  logic [2:0]           new_phase,
  input  logic                 reverse_direction,
  input  logic [7:0]           blank_reload,
  output ssc_pkg::ctrl_state_t state_next,
  output logic                 commutated,
  output logic                 adc_trigger
);
  import ssc_pkg::*;

  logic [2:0]  ph;
  step_row_t   srow;
  manual_row_t mrow;
  logic        expect_high;

  always_comb begin
    ph          = (state.phase <= LAST_PHASE) ? state.phase : 3'd0;
    srow        = reverse_direction ? STEP_REV[ph] : STEP_FWD[ph];
    mrow        = reverse_direction ? MANUAL_REV[ph] : MANUAL_FWD[ph];
    // even phases wait for a rising crossing
    expect_high = ~ph[0];
  end

  always_comb begin
    state_next  = state;
    commutated  = 1'b0;
    adc_trigger = 1'b0;
    case (op)
      OP_SAMPLE: begin
        if (state.blank_count == 8'd0) begin
          if (comp_high == expect_high) begin
            state_next.high_sel    = srow.hc;
            state_next.low_sel     = srow.lc;
            state_next.sense_sel   = srow.sns;
            state_next.edge_rising = srow.rise;
            state_next.phase       = (ph == LAST_PHASE) ? 3'd0 : ph + 3'd1;
            state_next.blank_count = blank_reload;
            commutated             = 1'b1;
            adc_trigger            = adc_window;
          end else begin
            state_next.high_sel = srow.hs;
            state_next.low_sel  = srow.ls;
          end
        end
      end
      OP_TICK: begin
        if (state.blank_count != 8'd0) begin
          state_next.blank_count = state.blank_count - 8'd1;
        end
      end
      OP_MANUAL: begin
        state_next.high_sel    = mrow.hi;
        state_next.low_sel     = mrow.lo;
        state_next.sense_sel   = mrow.sns;
        state_next.edge_rising = mrow.rise;
      end
      OP_LOAD: begin
        if (new_phase <= LAST_PHASE) begin
          state_next.phase = new_phase;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

FILE: rtl/ssc_out_buf.sv
`timescale 1ns / 1ps

module ssc_out_buf (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ssc_pkg::OUT_DATA_W-1:0] in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ssc_pkg::OUT_DATA_W-1:0] out_data
);
  import ssc_pkg::*;

  logic                  main_valid;
  logic [OUT_DATA_W-1:0] main_data;
  logic                  skid_valid;
  logic [OUT_DATA_W-1:0] skid_data;
  logic                  push;
  logic                  pop;

  assign in_ready  = ~skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign push      = in_valid & in_ready;
  assign pop       = main_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // payload moves alongside the valid bits above
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end
  end

endmodule
